// ----- hdl/b64d_pkg.sv -----
package b64d_pkg;

  // Output queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_HIGH_BIT = 8'h80;
  localparam logic [7:0] CH_PAD      = 8'h3D;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

  // Sextet offsets of the alphabet ranges.
  localparam logic [5:0] SX_LOWER_BASE = 6'd26;
  localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SX_PLUS       = 6'd62;
  localparam logic [5:0] SX_SLASH      = 6'd63;

  // Masks for the leftover bits ahead of a pad.
  localparam logic [3:0] LEFT_MASK_2PAD = 4'hF;
  localparam logic [1:0] LEFT_MASK_1PAD = 2'h3;

  // Group positions.
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  // Byte counts of one queue entry.
  localparam logic [1:0] NB_NONE  = 2'd0;
  localparam logic [1:0] NB_ONE   = 2'd1;
  localparam logic [1:0] NB_TWO   = 2'd2;
  localparam logic [1:0] NB_THREE = 2'd3;

  typedef struct packed {
    logic       bad;
    logic [5:0] val;
  } sym_t;

  // One queue entry: the results caused by one input item.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            has_end;
    logic            bad;
  } qentry_t;

  // Map a character to its sextet, or flag it as outside the alphabet.
  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t s;
    s.bad = 1'b0;
    s.val = '0;
    if ((c & CH_HIGH_BIT) != 8'h00) begin
      s.bad = 1'b1;
    end else if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      s.val = 6'(c - CH_UPPER_A);
    end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      s.val = 6'(c - CH_LOWER_A) + SX_LOWER_BASE;
    end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
      s.val = 6'(c - CH_DIGIT_0) + SX_DIGIT_BASE;
    end else if (c == CH_PLUS) begin
      s.val = SX_PLUS;
    end else if (c == CH_SLASH) begin
      s.val = SX_SLASH;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

// ----- hdl/b64d_front.sv -----
module b64d_front import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_text,
  input  logic       q_full,
  output logic       q_push,
  output qentry_t    q_entry
);

  logic [1:0]  group_pos_r, group_pos_nxt;
  logic [17:0] sextets_r, sextets_nxt;
  logic        pad_at_third_r, pad_at_third_nxt;
  logic        closed_r, closed_nxt;
  logic        failed_r, failed_nxt;

  logic        accept;
  logic        is_space;
  logic        is_pad;
  logic        take;
  sym_t        sym;
  logic [1:0]  nbytes;
  logic        fail_final;
  logic [5:0]  s1, s2, s3;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the character.
  assign sym      = sym_decode(in_ch);
  assign is_pad   = (in_ch == CH_PAD);
  assign is_space = in_ch inside {CH_LF, CH_CR, CH_SPACE, CH_TAB, CH_NUL};
  assign take     = !failed_r && !is_space;

  assign s1 = sextets_r[17:12];
  assign s2 = sextets_r[11:6];
  assign s3 = sextets_r[5:0];

  // Group decoding and error checks.
  always_comb begin
    group_pos_nxt    = group_pos_r;
    sextets_nxt      = sextets_r;
    pad_at_third_nxt = pad_at_third_r;
    closed_nxt       = closed_r;
    failed_nxt       = failed_r;
    nbytes           = NB_NONE;
    if (take) begin
      if ((sym.bad && !is_pad) || closed_r) begin
        failed_nxt = 1'b1;
      end else begin
        case (group_pos_r)
          POS_FIRST: begin
            if (is_pad) begin
              failed_nxt = 1'b1;
            end else begin
              sextets_nxt   = {sym.val, 12'h000};
              group_pos_nxt = POS_SECOND;
            end
          end
          POS_SECOND: begin
            if (is_pad) begin
              failed_nxt = 1'b1;
            end else begin
              sextets_nxt[11:6] = sym.val;
              group_pos_nxt     = POS_THIRD;
            end
          end
          POS_THIRD: begin
            if (is_pad) begin
              if ((s2[3:0] & LEFT_MASK_2PAD) != 4'h0) begin
                failed_nxt = 1'b1;
              end else begin
                pad_at_third_nxt = 1'b1;
                group_pos_nxt    = POS_FOURTH;
              end
            end else begin
              sextets_nxt[5:0] = sym.val;
              group_pos_nxt    = POS_FOURTH;
            end
          end
          default: begin
            group_pos_nxt = POS_FIRST;
            if (pad_at_third_r) begin
              if (!is_pad) begin
                failed_nxt = 1'b1;
              end else begin
                pad_at_third_nxt = 1'b0;
                closed_nxt       = 1'b1;
                nbytes           = NB_ONE;
              end
            end else if (is_pad) begin
              if ((s3[1:0] & LEFT_MASK_1PAD) != 2'h0) begin
                failed_nxt = 1'b1;
              end else begin
                closed_nxt = 1'b1;
                nbytes     = NB_TWO;
              end
            end else begin
              nbytes = NB_THREE;
            end
          end
        endcase
      end
    end
    fail_final = failed_nxt || (group_pos_nxt != POS_FIRST);
    // The final character closes the stream and clears all state.
    if (in_end_of_text) begin
      group_pos_nxt    = POS_FIRST;
      sextets_nxt      = '0;
      pad_at_third_nxt = 1'b0;
      closed_nxt       = 1'b0;
      failed_nxt       = 1'b0;
    end
  end

  // Entry for the queue.
  always_comb begin
    q_entry.bytes[0] = {s1, s2[5:4]};
    q_entry.bytes[1] = {s2[3:0], s3[5:2]};
    q_entry.bytes[2] = {s3[1:0], sym.val};
    q_entry.nbytes   = nbytes;
    q_entry.has_end  = in_end_of_text;
    q_entry.bad      = in_end_of_text && fail_final;
  end

  assign q_push = accept && ((nbytes != NB_NONE) || in_end_of_text);

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_pos_r    <= POS_FIRST;
      sextets_r      <= '0;
      pad_at_third_r <= 1'b0;
      closed_r       <= 1'b0;
      failed_r       <= 1'b0;
    end else if (accept) begin
      group_pos_r    <= group_pos_nxt;
      sextets_r      <= sextets_nxt;
      pad_at_third_r <= pad_at_third_nxt;
      closed_r       <= closed_nxt;
      failed_r       <= failed_nxt;
    end
  end

endmodule

// ----- hdl/b64d_queue.sv -----
module b64d_queue import b64d_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t wr_entry,
  input  logic    pop,
  output qentry_t rd_entry,
  output logic    full,
  output logic    empty
);

  qentry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign rd_entry = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("Queue written while full.");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("Queue read while empty.");
  a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (wr_entry.nbytes != NB_NONE || wr_entry.has_end))
    else $error("Queue entry carries no result.");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("Fill count did not advance on a write.");
`endif

endmodule

// ----- hdl/b64d_back.sv -----
module b64d_back import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  qentry_t    q_entry,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data,
  output logic       out_is_end,
  output logic       out_bad_input
);

  qentry_t    work_r, work_nxt;
  logic       work_valid_r, work_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       last;
  logic       done;
  logic       is_status;

  // Position within the current entry: bytes first, then the status.
  assign total     = {1'b0, work_r.nbytes} + {2'b00, work_r.has_end};
  assign last      = ({1'b0, idx_r} == (total - 3'd1));
  assign is_status = (idx_r >= work_r.nbytes);
  assign done      = !work_valid_r || (out_ready && last);
  assign q_pop     = done && !q_empty;

  assign out_valid     = work_valid_r;
  assign out_is_end    = is_status;
  assign out_bad_input = is_status && work_r.bad;

  // Byte selection.
  always_comb begin
    case (idx_r)
      2'd0:    out_data = work_r.bytes[0];
      2'd1:    out_data = work_r.bytes[1];
      2'd2:    out_data = work_r.bytes[2];
      default: out_data = 8'h00;
    endcase
    if (is_status) begin
      out_data = 8'h00;
    end
  end

  // Load the next entry once the current one is drained.
  always_comb begin
    work_nxt       = work_r;
    work_valid_nxt = work_valid_r;
    idx_nxt        = idx_r;
    if (done) begin
      work_valid_nxt = !q_empty;
      work_nxt       = q_entry;
      idx_nxt        = '0;
    end else if (out_ready) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      work_valid_r <= work_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

`ifndef SYNTHESIS
  a_status_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_end) |-> (out_data == 8'h00))
    else $error("Status item carries nonzero data.");
  a_bad_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_input) |-> out_is_end)
    else $error("Error flag on a byte item.");
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, idx_r} < total))
    else $error("Result index past the end of the entry.");
`endif

endmodule

// ----- hdl/base64_stream_decoder.sv -----
// Channel | Direction | Ports                                   | Handshake
// input   | in        | in_ch, in_end_of_text                   | in_valid / in_ready
// result  | out       | out_data, out_is_end, out_bad_input     | out_valid / out_ready
//
// The front decodes one character per cycle; in_ready is low only while the
// four-entry queue is full. The back sends one result item per cycle while
// out_ready is high, so a character that completes a group yields up to four
// result items (three bytes and a status). Results pass through the queue and
// the back's work register. Reset is synchronous on rst_n and empties the queue
// and clears the group state. Either side may stall without losing or repeating items.
module base64_stream_decoder import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data,
  output logic       out_is_end,
  output logic       out_bad_input
);

  logic    q_full;
  logic    q_empty;
  logic    q_push;
  logic    q_pop;
  qentry_t q_wr_entry;
  qentry_t q_rd_entry;

  // Character decoding and group state.
  b64d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_wr_entry)
  );

  // Queue of per-character result groups.
  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Serializer onto the result channel.
  b64d_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_entry       (q_rd_entry),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .out_is_end    (out_is_end),
    .out_bad_input (out_bad_input)
  );

endmodule
